@@ rtl/rat_pkg.sv @@
// ============================================================================
// rat_pkg: shared types and constants for the rational accumulator ALU
// Holds the default width, command and status codes, the sequencer state type
// and the iterative-unit handshake.
package rat_pkg;

   localparam int unsigned VALUE_WIDTH_DEF = 32;

   typedef enum logic [2:0] {
      CMD_LOAD = 3'd0,
      CMD_ADD  = 3'd1,
      CMD_SUB  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4
   } cmd_type;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVF  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_ADD,
      ST_GCD_START,
      ST_GCD_WAIT,
      ST_DIVN_START,
      ST_DIVN_WAIT,
      ST_DIVD_START,
      ST_DIVD_WAIT,
      ST_CHECK,
      ST_OUT
   } state_type;

   // handshake to the shared iterative unit
   typedef struct packed {
      logic start;
      logic op_gcd;   // 1: binary gcd, 0: unsigned divide
   } iter_ctl_type;

endpackage

@@ rtl/rat_mul.sv @@
// ============================================================================
// rat_mul: registered magnitude multiplier
// One 32x32 unsigned product per cycle, result registered.
// ============================================================================
module rat_mul #(
   parameter int unsigned VALUE_WIDTH = rat_pkg::VALUE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic [VALUE_WIDTH-1:0]     a,
   input  logic [VALUE_WIDTH-1:0]     b,
   output logic [2*VALUE_WIDTH-1:0]   p
);
   logic [2*VALUE_WIDTH-1:0] p_ff;
   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end
   assign p = p_ff;
endmodule

@@ rtl/rat_iter.sv @@
// ============================================================================
// rat_iter: shared iterative unit
// Binary gcd (one step per cycle) or restoring divide (one bit per cycle).
// ============================================================================
module rat_iter #(
   parameter int unsigned W = 2 * rat_pkg::VALUE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rat_pkg::iter_ctl_type ctl,
   input  logic [W-1:0]          a,
   input  logic [W-1:0]          b,
   output logic                  done,
   output logic [W-1:0]          res
);
   localparam int unsigned CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          gcd_ff, gcd_in;
   logic [W-1:0]  x_ff, x_in;     // gcd a / divide quotient-dividend
   logic [W-1:0]  y_ff, y_in;     // gcd b / divisor
   logic [W:0]    r_ff, r_in;     // divide remainder
   logic [CW-1:0] k_ff, k_in;     // gcd common twos / divide count
   logic          done_ff, done_in;
   logic [W-1:0]  res_ff, res_in;
   logic [W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      gcd_in  = gcd_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      k_in    = k_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      trial   = {r_ff[W-1:0], x_ff[W-1]} - {1'b0, y_ff};
      if (ctl.start) begin
         busy_in = 1'b1;
         gcd_in  = ctl.op_gcd;
         x_in    = a;
         y_in    = b;
         r_in    = '0;
         k_in    = '0;
      end else if (busy_ff) begin
         if (gcd_ff) begin
            if (x_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               res_in  = y_ff << k_ff;
            end else if (y_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               res_in  = x_ff << k_ff;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end else begin
            if (!trial[W]) begin
               r_in = trial;
               x_in = {x_ff[W-2:0], 1'b1};
            end else begin
               r_in = {r_ff[W-1:0], x_ff[W-1]};
               x_in = {x_ff[W-2:0], 1'b0};
            end
            k_in = k_ff + 1'b1;
            if (k_ff == CW'(W - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               res_in  = x_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      gcd_ff <= gcd_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
      k_ff   <= k_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff) else $error("start while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
endmodule

@@ rtl/rational_accumulator_alu_core.sv @@
// ============================================================================
// rational_accumulator_alu_core: fraction accumulator with gcd reduction
// Load/add/sub/mul/div a fraction into the accumulator, reduce, return it.
// ============================================================================
// Sequence: error and unknown-command beats go from ST_MUL0 straight to ST_OUT.
//   Other beats run ST_MUL0, ST_MUL1, ST_MUL2 and ST_ADD for products and sum,
//   then the binary gcd, two 2W-bit divides by the gcd (numerator, then
//   denominator) and the range check in ST_CHECK before ST_OUT.
// Throughput: one beat at a time; req_stall is high from accept to rsp take.
// Reset: accumulator 0/1, idle.
module rational_accumulator_alu_core #(
   parameter int unsigned VALUE_WIDTH = rat_pkg::VALUE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_command,
   input  logic signed [31:0]      req_operand_numerator,
   input  logic signed [31:0]      req_operand_denominator,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_result_numerator,
   output logic [30:0]             rsp_result_denominator,
   output logic [1:0]              rsp_status
);
   localparam int unsigned W  = 32;       // operand magnitude width
   localparam int unsigned PW = 2 * W;    // product width

   rat_pkg::state_type state_ff, state_in;

   logic [2:0]    cmd_ff, cmd_in;
   logic [W-1:0]  onm_ff, onm_in, odm_ff, odm_in;   // operand magnitudes
   logic          onn_ff, onn_in, odn_ff, odn_in;   // operand signs
   logic [31:0]   accn_ff, accn_in;
   logic [31:0]   accd_ff, accd_in;
   logic [PW-1:0] p0_ff, p0_in, p1_ff, p1_in;       // numerator terms
   logic          s0_ff, s0_in, s1_ff, s1_in;
   logic [PW:0]   nm_ff, nm_in;                     // numerator magnitude (sum may carry)
   logic          nneg_ff, nneg_in;
   logic [PW-1:0] dm_ff, dm_in;
   logic [PW-1:0] g_ff, g_in, qn_ff, qn_in;
   logic [1:0]    st_ff, st_in;

   // shared multiplier
   logic [W-1:0]  ma, mb;
   logic [PW-1:0] mp;

   // shared iterative unit
   rat_pkg::iter_ctl_type ictl;
   logic [PW-1:0] ia, ib, ires;
   logic          idone;

   logic [W-1:0]  an_mag;
   logic          an_neg;
   logic [PW:0]   lim;
   logic          ok;

   rat_mul #(.VALUE_WIDTH(W)) u_mul (.clock(clock), .a(ma), .b(mb), .p(mp));

   rat_iter #(.W(PW)) u_iter (
      .clock(clock), .reset(reset), .ctl(ictl),
      .a(ia), .b(ib), .done(idone), .res(ires)
   );

   assign an_neg = accn_ff[31];
   assign an_mag = an_neg ? (~accn_ff + 1'b1) : accn_ff;
   assign lim    = (PW+1)'(1) << (VALUE_WIDTH - 1);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;  onm_in = onm_ff; odm_in = odm_ff;
      onn_in = onn_ff;  odn_in = odn_ff;
      accn_in = accn_ff; accd_in = accd_ff;
      p0_in = p0_ff; p1_in = p1_ff; s0_in = s0_ff; s1_in = s1_ff;
      nm_in = nm_ff; nneg_in = nneg_ff; dm_in = dm_ff;
      g_in = g_ff; qn_in = qn_ff; st_in = st_ff;
      ma = '0; mb = '0;
      ictl = '0; ia = '0; ib = '0;
      ok = 1'b0;
      case (state_ff)
         rat_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               onn_in = req_operand_numerator[31];
               odn_in = req_operand_denominator[31];
               onm_in = req_operand_numerator[31] ?
                        (~req_operand_numerator + 1'b1) : req_operand_numerator;
               odm_in = req_operand_denominator[31] ?
                        (~req_operand_denominator + 1'b1) : req_operand_denominator;
               state_in = rat_pkg::ST_MUL0;
            end
         end
         rat_pkg::ST_MUL0: begin
            st_in = rat_pkg::STATUS_OK;
            if (cmd_ff > 3'(rat_pkg::CMD_DIV)) begin
               state_in = rat_pkg::ST_OUT;
            end else if (odm_ff == '0 ||
                         (cmd_ff == 3'(rat_pkg::CMD_DIV) && onm_ff == '0)) begin
               st_in = rat_pkg::STATUS_ZERO;
               state_in = rat_pkg::ST_OUT;
            end else begin
               // first product: numerator term (or plain load)
               case (cmd_ff)
                  3'(rat_pkg::CMD_LOAD): begin ma = onm_ff; mb = W'(1); end
                  3'(rat_pkg::CMD_MUL):  begin ma = an_mag; mb = onm_ff; end
                  default:               begin ma = an_mag; mb = odm_ff; end
               endcase
               state_in = rat_pkg::ST_MUL1;
            end
         end
         rat_pkg::ST_MUL1: begin
            p0_in = mp;
            s0_in = (cmd_ff == 3'(rat_pkg::CMD_LOAD)) ? onn_ff :
                    (cmd_ff == 3'(rat_pkg::CMD_MUL)) ? (an_neg ^ onn_ff) :
                    (an_neg ^ odn_ff);
            // second product: denominator
            case (cmd_ff)
               3'(rat_pkg::CMD_LOAD): begin ma = odm_ff; mb = W'(1); end
               3'(rat_pkg::CMD_DIV):  begin ma = accd_ff; mb = onm_ff; end
               default:               begin ma = accd_ff; mb = odm_ff; end
            endcase
            state_in = rat_pkg::ST_MUL2;
         end
         rat_pkg::ST_MUL2: begin
            dm_in = mp;
            // accumulator denominator is positive
            nneg_in = (cmd_ff == 3'(rat_pkg::CMD_LOAD)) ? odn_ff :
                      (cmd_ff == 3'(rat_pkg::CMD_DIV)) ? onn_ff : odn_ff;
            ma = accd_ff; mb = onm_ff;    // cross term for add/sub
            state_in = rat_pkg::ST_ADD;
         end
         rat_pkg::ST_ADD: begin
            p1_in = mp;
            s1_in = onn_ff ^ (cmd_ff == 3'(rat_pkg::CMD_SUB));
            if (cmd_ff == 3'(rat_pkg::CMD_ADD) || cmd_ff == 3'(rat_pkg::CMD_SUB)) begin
               if (s0_ff == s1_in) begin
                  nm_in = {1'b0, p0_ff} + {1'b0, mp};
                  s0_in = s0_ff;
               end else if (p0_ff >= mp) begin
                  nm_in = {1'b0, p0_ff - mp};
                  s0_in = s0_ff;
               end else begin
                  nm_in = {1'b0, mp - p0_ff};
                  s0_in = s1_in;
               end
            end else begin
               nm_in = {1'b0, p0_ff};
            end
            state_in = rat_pkg::ST_GCD_START;
         end
         rat_pkg::ST_GCD_START: begin
            // final sign: numerator sign xor denominator sign, zero is positive
            nneg_in = (nm_ff != '0) && (s0_ff ^ nneg_ff);
            ictl.start = 1'b1; ictl.op_gcd = 1'b1;
            ia = nm_ff[PW-1:0]; ib = dm_ff;
            state_in = rat_pkg::ST_GCD_WAIT;
         end
         rat_pkg::ST_GCD_WAIT: begin
            if (idone) begin
               g_in = ires;
               state_in = rat_pkg::ST_DIVN_START;
            end
         end
         rat_pkg::ST_DIVN_START: begin
            ictl.start = 1'b1;
            ia = nm_ff[PW-1:0]; ib = g_ff;
            state_in = rat_pkg::ST_DIVN_WAIT;
         end
         rat_pkg::ST_DIVN_WAIT: begin
            if (idone) begin
               qn_in = ires;
               state_in = rat_pkg::ST_DIVD_START;
            end
         end
         rat_pkg::ST_DIVD_START: begin
            ictl.start = 1'b1;
            ia = dm_ff; ib = g_ff;
            state_in = rat_pkg::ST_DIVD_WAIT;
         end
         rat_pkg::ST_DIVD_WAIT: begin
            if (idone) begin
               dm_in = ires;
               state_in = rat_pkg::ST_CHECK;
            end
         end
         rat_pkg::ST_CHECK: begin
            ok = (nneg_ff ? ({1'b0, qn_ff} <= lim) : ({1'b0, qn_ff} < lim)) &&
                 ({1'b0, dm_ff} < lim) && !nm_ff[PW];
            if (ok) begin
               accn_in = nneg_ff ? (~qn_ff[31:0] + 1'b1) : qn_ff[31:0];
               accd_in = dm_ff[31:0];
            end else begin
               st_in = rat_pkg::STATUS_OVF;
            end
            state_in = rat_pkg::ST_OUT;
         end
         rat_pkg::ST_OUT: begin
            if (!rsp_stall) state_in = rat_pkg::ST_IDLE;
         end
         default: state_in = rat_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rat_pkg::ST_IDLE;
         accn_ff  <= '0;
         accd_ff  <= 32'd1;
      end else begin
         state_ff <= state_in;
         accn_ff  <= accn_in;
         accd_ff  <= accd_in;
      end
      cmd_ff <= cmd_in; onm_ff <= onm_in; odm_ff <= odm_in;
      onn_ff <= onn_in; odn_ff <= odn_in;
      p0_ff <= p0_in; p1_ff <= p1_in; s0_ff <= s0_in; s1_ff <= s1_in;
      nm_ff <= nm_in; nneg_ff <= nneg_in; dm_ff <= dm_in;
      g_ff <= g_in; qn_ff <= qn_in; st_ff <= st_in;
   end

   assign req_stall              = (state_ff != rat_pkg::ST_IDLE);
   assign rsp_valid              = (state_ff == rat_pkg::ST_OUT);
   assign rsp_result_numerator   = accn_ff;
   assign rsp_result_denominator = accd_ff[30:0];
   assign rsp_status             = st_ff;

   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      accd_ff != '0 && !accd_ff[31]) else $error("acc denominator not positive");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(accn_ff))
      else $error("result changed while stalled");
   a_err_keep: assert property (@(posedge clock) disable iff (reset)
      state_ff == rat_pkg::ST_CHECK && !ok |=> $stable(accn_ff) && $stable(accd_ff))
      else $error("overflow altered accumulator");
endmodule

@@ test/rational_accumulator_alu_core_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// rational_accumulator_alu_core_checker: fraction accumulator scoreboard
// Watches both channels. For each accepted request beat it computes the
// expected accumulator and status and queues them. Each response beat is
// compared with the oldest queued entry.
// ============================================================================
module rational_accumulator_alu_core_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_operand_numerator,
   input  logic signed [31:0] req_operand_denominator,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_result_numerator,
   input  logic [30:0]        rsp_result_denominator,
   input  logic [1:0]         rsp_status,
   output int                 fail_count,
   output int                 pending
);
   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic [1:0]         status;
   } fraction_result_type;

   localparam longint VALUE_LIMIT = 64'sd1 << 31;

   logic signed [31:0]  acc_num;
   logic signed [31:0]  acc_den;
   fraction_result_type expected_fractions[$];

   function automatic longint abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint gcd64(longint a, longint b);
      longint t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Applies one command to acc_num/acc_den; returns the response beat.
   function automatic fraction_result_type apply_command(logic [2:0] cmd,
                                                         logic signed [31:0] op_n,
                                                         logic signed [31:0] op_d);
      fraction_result_type r;
      longint on, od, an, ad, n, d, g, nm, dm;
      logic   neg, ok;
      on = op_n;
      od = op_d;
      an = acc_num;
      ad = acc_den;
      r.status = rat_pkg::STATUS_OK;
      if (cmd <= rat_pkg::CMD_DIV) begin
         if (od == 0 || (cmd == rat_pkg::CMD_DIV && on == 0)) begin
            r.status = rat_pkg::STATUS_ZERO;
         end else begin
            case (cmd)
               rat_pkg::CMD_LOAD: begin n = on; d = od; end
               rat_pkg::CMD_ADD:  begin n = an * od + ad * on; d = ad * od; end
               rat_pkg::CMD_SUB:  begin n = an * od - ad * on; d = ad * od; end
               rat_pkg::CMD_MUL:  begin n = an * on; d = ad * od; end
               default:           begin n = an * od; d = ad * on; end
            endcase
            neg = (n != 0) && ((n < 0) != (d < 0));
            g   = gcd64(abs64(n), abs64(d));
            nm  = abs64(n) / g;
            dm  = abs64(d) / g;
            ok  = (neg ? nm <= VALUE_LIMIT : nm < VALUE_LIMIT) && dm < VALUE_LIMIT;
            if (!ok) begin
               r.status = rat_pkg::STATUS_OVF;
            end else begin
               acc_num = neg ? 32'(-nm) : 32'(nm);
               acc_den = 32'(dm);
            end
         end
      end
      r.num = acc_num;
      r.den = acc_den[30:0];
      return r;
   endfunction

   always @(posedge clock) begin
      fraction_result_type got, want;
      if (reset) begin
         acc_num = 0;
         acc_den = 1;
         expected_fractions.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_fractions.push_back(apply_command(req_command,
               req_operand_numerator, req_operand_denominator));
         if (rsp_valid && !rsp_stall) begin
            got.num    = rsp_result_numerator;
            got.den    = rsp_result_denominator;
            got.status = rsp_status;
            if (expected_fractions.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected response beat %0d/%0d status %0d",
                           $realtime, got.num, got.den, got.status);
            end else begin
               want = expected_fractions.pop_front();
               if (got.num !== want.num || got.den !== want.den
                   || got.status !== want.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch exp %0d/%0d st %0d, got %0d/%0d st %0d",
                              $realtime, want.num, want.den, want.status,
                              got.num, got.den, got.status);
               end
            end
         end
      end
      pending = expected_fractions.size();
   end

endmodule

@@ test/tb_rational_accumulator_alu_core.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_rational_accumulator_alu_core: regression for the fraction accumulator
// Drives directed corner beats, then random command streams under several
// idle/stall mixes, and leaves prediction and comparison to the checker.
// ============================================================================
module tb_rational_accumulator_alu_core;
   // commands past CMD_DIV are ignored by the block but still answered
   localparam logic [2:0] CMD_SPARE5 = 3'd5;
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;
   localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;
   localparam int RANDOM_BEATS = 1240;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_command;
   logic signed [31:0] req_operand_numerator;
   logic signed [31:0] req_operand_denominator;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_result_numerator;
   logic [30:0]        rsp_result_denominator;
   logic [1:0]         rsp_status;
   int                 fail_count;
   int                 pending;

   // idle/stall percentages for the current phase
   int                 send_idle_pct;
   int                 recv_stall_pct;

   rational_accumulator_alu_core DUT (.*);

   rational_accumulator_alu_core_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off well into the run so
   // the block sits on a finished result while the sender keeps offering.
   initial begin
      int cycle_count;
      cycle_count = 0;
      rsp_stall   = 1'b1;
      forever begin
         @(negedge clock);
         cycle_count++;
         if (cycle_count == 30000) begin
            rsp_stall <= 1'b1;
            repeat (900) @(negedge clock);
            cycle_count += 900;
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // One request beat: random idle gap, then hold it until accepted.
   task automatic send_beat(logic [2:0] cmd, logic signed [31:0] num,
                            logic signed [31:0] den);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid               <= 1'b1;
      req_command             <= cmd;
      req_operand_numerator   <= num;
      req_operand_denominator <= den;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_value(bit want_nonzero);
      logic signed [31:0] v;
      case ($urandom_range(9))
         0:       v = $urandom();
         1:       v = $urandom_range(1) ? MOST_NEG : MOST_POS;
         2, 3:    v = $signed($urandom_range(200000)) - 100000;
         default: v = $signed($urandom_range(40)) - 20;
      endcase
      if (want_nonzero && v == 0)
         v = 1;
      return v;
   endfunction

   task automatic random_beat();
      logic [2:0]         cmd;
      logic signed [31:0] num, den;
      int                 roll;
      roll = $urandom_range(99);
      if (roll < 20)      cmd = rat_pkg::CMD_LOAD;
      else if (roll < 95) cmd = 3'($urandom_range(rat_pkg::CMD_ADD, rat_pkg::CMD_DIV));
      else                cmd = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
      num = pick_value($urandom_range(19) != 0);
      den = pick_value($urandom_range(29) != 0);
      send_beat(cmd, num, den);
   endtask

   initial begin
      int waited;
      reset                   = 1'b1;
      req_valid               = 1'b0;
      req_command             = rat_pkg::CMD_LOAD;
      req_operand_numerator   = 0;
      req_operand_denominator = 1;
      send_idle_pct           = 0;
      recv_stall_pct          = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners
      send_beat(rat_pkg::CMD_ADD, 0, 1);
      send_beat(rat_pkg::CMD_LOAD, MOST_NEG, 1);
      send_beat(rat_pkg::CMD_LOAD, MOST_POS, 1);
      send_beat(rat_pkg::CMD_LOAD, MOST_NEG, -1);   // negating most-negative overflows
      send_beat(rat_pkg::CMD_LOAD, 1, MOST_NEG);    // denominator 2^31 overflows
      send_beat(rat_pkg::CMD_LOAD, -1, MOST_NEG);
      send_beat(rat_pkg::CMD_LOAD, 6, -4);          // reduce and move sign up
      send_beat(rat_pkg::CMD_ADD, 1, 3);
      send_beat(rat_pkg::CMD_SUB, -5, 7);
      send_beat(rat_pkg::CMD_MUL, 7, -9);
      send_beat(rat_pkg::CMD_DIV, -3, 11);
      send_beat(rat_pkg::CMD_DIV, 0, 5);            // divide by zero
      send_beat(rat_pkg::CMD_LOAD, 4, 0);           // zero denominator, each command
      send_beat(rat_pkg::CMD_ADD, 4, 0);
      send_beat(rat_pkg::CMD_SUB, 4, 0);
      send_beat(rat_pkg::CMD_MUL, 4, 0);
      send_beat(rat_pkg::CMD_DIV, 4, 0);
      send_beat(CMD_SPARE5, 3, 0);
      send_beat(CMD_SPARE6, MOST_NEG, MOST_NEG);
      send_beat(CMD_SPARE7, -1, -1);
      send_beat(rat_pkg::CMD_MUL, 0, 3);            // zero result reads 0/1
      send_beat(rat_pkg::CMD_LOAD, MOST_POS, MOST_POS);
      send_beat(rat_pkg::CMD_ADD, MOST_POS, 1);     // sum overflow
      send_beat(rat_pkg::CMD_LOAD, 1, MOST_POS);
      send_beat(rat_pkg::CMD_MUL, 1, 3);            // denominator overflow

      // random phases: none, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 76 : (phase == 3) ? 14 : 0;
         recv_stall_pct = (phase == 2) ? 76 : (phase == 3) ? 14 : 0;
         for (int i = 0; i < RANDOM_BEATS / 4; i++)
            random_beat();
      end
      req_valid <= 1'b0;

      waited = 0;
      while (pending != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (500) @(posedge clock);
      if (pending == 0 && fail_count == 0)
         $display("rational_accumulator_alu_core regression: pass");
      else
         $display("rational_accumulator_alu_core regression: fail");
      $finish;
   end

   initial begin
      #80ms;
      $display("rational_accumulator_alu_core regression: fail");
      $finish;
   end

endmodule
